FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CMTP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CMTP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/cmtp_pkg.sv
// Types, constants and defaults for the caret markup text parser.
`timescale 1ns / 1ps

package cmtp_pkg;

    localparam int MAX_CHARS_DEF    = 2048;
    localparam int NAME_LIMIT_DEF   = 50;
    localparam int NUMBER_LIMIT_DEF = 10;

    localparam int ADDR_W       = 4;
    localparam int DATA_W       = 32;
    localparam int MAX_PER_ITEM = 3;
    localparam int OUTQ_DEPTH   = 4;

    localparam logic [1:0] REG_COLOR     = 2'd0;
    localparam logic [1:0] REG_UNDERLINE = 2'd1;
    localparam logic [1:0] REG_STYLE     = 2'd2;
    localparam logic [1:0] REG_SIZE      = 2'd3;

    localparam logic [7:0] RST_COLOR     = 8'd2;
    localparam logic [7:0] RST_UNDERLINE = 8'd2;
    localparam logic [7:0] RST_STYLE     = 8'd0;
    localparam logic [15:0] RST_SIZE     = 16'd0;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_CARET  = 8'h5e;
    localparam logic [7:0] CH_DEL    = 8'h7f;

    localparam logic [7:0] CMD_STYLE = 8'h61;
    localparam logic [7:0] CMD_COLOR = 8'h63;
    localparam logic [7:0] CMD_FONT  = 8'h66;
    localparam logic [7:0] CMD_LINE  = 8'h6c;
    localparam logic [7:0] CMD_SIZE  = 8'h73;
    localparam logic [7:0] CMD_UNDER = 8'h75;

    typedef struct packed {
        logic [7:0]  color;
        logic [7:0]  underline;
        logic [7:0]  style;
        logic [15:0] size;
    } attr_t;

    typedef struct packed {
        logic [7:0] code;
        attr_t      attr;
        logic       eot;
    } item_t;

endpackage

FILE: src/caret_markup_text_parser.sv
// Top level of the caret markup text parser: config registers, input stage, parse, result queue.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------------------
//  text     | in        | text_valid, text_stall | text_byte, final_byte
//  char     | out       | char_valid, char_stall | char_code, color, underline_color, style,
//           |           |                        | font_size, char_count, end_of_text
//  config   | in        | APB psel/penable       | paddr, pwdata, prdata
//
// One byte is taken per cycle unless text_stall is high; each byte is registered before parsing.
// A byte yields 0 to 3 items; the output side drains one item per cycle unless char_stall
// is high, so a run of bytes that each yield more than one item is paced by the result queue.
// The input register holds a byte until the queue has room for three items.
// Reset clears parse state and the queue; config registers return to their defaults.
`timescale 1ns / 1ps

module caret_markup_text_parser import cmtp_pkg::*; #(
    parameter int MAX_CHARS    = MAX_CHARS_DEF,
    parameter int NAME_LIMIT   = NAME_LIMIT_DEF,
    parameter int NUMBER_LIMIT = NUMBER_LIMIT_DEF,
    parameter int CNT_W        = $clog2(MAX_CHARS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              text_valid,
    output logic              text_stall,
    input  logic [7:0]        text_byte,
    input  logic              final_byte,
    output logic              char_valid,
    input  logic              char_stall,
    output logic [7:0]        char_code,
    output logic [7:0]        color,
    output logic [7:0]        underline_color,
    output logic [7:0]        style,
    output logic [15:0]       font_size,
    output logic [CNT_W-1:0]  char_count,
    output logic              end_of_text
);

    localparam int ITEM_W = $bits(item_t) + CNT_W;

    attr_t            def_reg;
    logic [1:0]       reg_idx;
    logic             cfg_wr;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_fin_reg;
    logic             room;
    logic             fire;
    logic             take;

    logic [1:0]        n_items;
    item_t             items  [MAX_PER_ITEM];
    logic [CNT_W-1:0]  counts [MAX_PER_ITEM];
    logic [ITEM_W-1:0] push_data [MAX_PER_ITEM];
    logic [ITEM_W-1:0] pop_data;
    item_t             head;
    logic [1:0]        push_n;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_COLOR:     prdata = {24'd0, def_reg.color};
            REG_UNDERLINE: prdata = {24'd0, def_reg.underline};
            REG_STYLE:     prdata = {24'd0, def_reg.style};
            REG_SIZE:      prdata = {16'd0, def_reg.size};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_reg <= '{color: RST_COLOR, underline: RST_UNDERLINE,
                         style: RST_STYLE, size: RST_SIZE};
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_COLOR:     def_reg.color <= pwdata[7:0];
                REG_UNDERLINE: def_reg.underline <= pwdata[7:0];
                REG_STYLE:     def_reg.style <= pwdata[7:0];
                REG_SIZE:      def_reg.size <= pwdata[15:0];
            endcase
        end
    end

    assign fire       = in_valid_reg && room;
    assign text_stall = in_valid_reg && !room;
    assign take       = text_valid && !text_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (take)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_byte_reg <= text_byte;
            in_fin_reg  <= final_byte;
        end
    end

    cmtp_parse #(
        .MAX_CHARS    (MAX_CHARS),
        .NAME_LIMIT   (NAME_LIMIT),
        .NUMBER_LIMIT (NUMBER_LIMIT),
        .CNT_W        (CNT_W)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .byte_in  (in_byte_reg),
        .fin_in   (in_fin_reg),
        .defaults (def_reg),
        .n_items  (n_items),
        .items    (items),
        .counts   (counts)
    );

    assign push_n = fire ? n_items : 2'd0;

    always_comb
    begin
        for (int i = 0; i < MAX_PER_ITEM; i++)
            push_data[i] = {items[i], counts[i]};
    end

    cmtp_outq #(
        .WIDTH (ITEM_W)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_data (push_data),
        .room      (room),
        .pop_valid (char_valid),
        .pop_stall (char_stall),
        .pop_data  (pop_data)
    );

    assign head            = pop_data[ITEM_W-1:CNT_W];
    assign char_count      = pop_data[CNT_W-1:0];
    assign char_code       = head.code;
    assign color           = head.attr.color;
    assign underline_color = head.attr.underline;
    assign style           = head.attr.style;
    assign font_size       = head.attr.size;
    assign end_of_text     = head.eot;

endmodule

FILE: src/cmtp_parse.sv
// Parse state and per-byte step: turns one byte into up to three result items.
`timescale 1ns / 1ps

module cmtp_parse import cmtp_pkg::*; #(
    parameter int MAX_CHARS    = MAX_CHARS_DEF,
    parameter int NAME_LIMIT   = NAME_LIMIT_DEF,
    parameter int NUMBER_LIMIT = NUMBER_LIMIT_DEF,
    parameter int CNT_W        = $clog2(MAX_CHARS + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       byte_in,
    input  logic             fin_in,
    input  attr_t            defaults,
    output logic [1:0]       n_items,
    output item_t            items [MAX_PER_ITEM],
    output logic [CNT_W-1:0] counts [MAX_PER_ITEM]
);

    localparam logic [2:0] MODE_TEXT = 3'd0;
    localparam logic [2:0] MODE_CMD  = 3'd1;
    localparam logic [2:0] MODE_NAME = 3'd2;
    localparam logic [2:0] MODE_NUM  = 3'd3;
    localparam logic [2:0] MODE_SKIP = 3'd4;

    localparam logic [1:0] TGT_COLOR = 2'd0;
    localparam logic [1:0] TGT_UNDER = 2'd1;
    localparam logic [1:0] TGT_STYLE = 2'd2;
    localparam logic [1:0] TGT_SIZE  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHARS);
    localparam logic [5:0] NAME_LIM = 6'(NAME_LIMIT);
    localparam logic [5:0] NUM_LIM  = 6'(NUMBER_LIMIT);

    logic [2:0]       mode_reg, mode_next;
    logic [1:0]       tgt_reg, tgt_next;
    logic [5:0]       plen_reg, plen_next;
    logic [15:0]      acc_reg, acc_next;
    logic             neg_reg, neg_next;
    logic             digit_reg, digit_next;
    logic             ended_reg, ended_next;
    logic             sign_reg, sign_next;
    logic             bs_reg, bs_next;
    logic             open_reg, open_next;
    attr_t            attr_reg, attr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        logic [7:0]       c;
        logic             pass;
        logic             num_start;
        logic [1:0]       r;
        logic             req_v    [MAX_PER_ITEM];
        logic [7:0]       req_code [MAX_PER_ITEM];
        logic             req_end  [MAX_PER_ITEM];
        logic [19:0]      prod;
        logic [7:0]       low;
        logic [1:0]       k;
        logic [CNT_W-1:0] cc;

        c = byte_in;
        r = 2'd0;
        num_start = 1'b0;
        prod = 20'd0;
        low = 8'd0;
        for (int i = 0; i < MAX_PER_ITEM; i++)
        begin
            req_v[i]    = 1'b0;
            req_code[i] = 8'd0;
            req_end[i]  = 1'b0;
        end

        if (open_reg)
        begin
            mode_next  = mode_reg;
            tgt_next   = tgt_reg;
            plen_next  = plen_reg;
            acc_next   = acc_reg;
            neg_next   = neg_reg;
            digit_next = digit_reg;
            ended_next = ended_reg;
            sign_next  = sign_reg;
            bs_next    = bs_reg;
            attr_next  = attr_reg;
            cnt_next   = cnt_reg;
        end
        else
        begin
            mode_next  = MODE_TEXT;
            tgt_next   = TGT_COLOR;
            plen_next  = 6'd0;
            acc_next   = 16'd0;
            neg_next   = 1'b0;
            digit_next = 1'b0;
            ended_next = 1'b0;
            sign_next  = 1'b0;
            bs_next    = 1'b0;
            attr_next  = defaults;
            cnt_next   = '0;
        end
        open_next = 1'b1;

        pass = (c >= CH_SPACE && c != CH_DEL) || c == CH_CR || c == CH_BS ||
               c == CH_FF || c == CH_LF;

        unique case (mode_next)
            MODE_TEXT:
            begin
                if (bs_next && c == CH_QUOTE)
                begin
                    bs_next = 1'b0;
                    req_v[r] = 1'b1;
                    req_code[r] = CH_QUOTE;
                    r = r + 2'd1;
                end
                else
                begin
                    if (bs_next)
                    begin
                        bs_next = 1'b0;
                        req_v[r] = 1'b1;
                        req_code[r] = CH_BSLASH;
                        r = r + 2'd1;
                    end
                    if (c == CH_CARET)
                        mode_next = MODE_CMD;
                    else if (pass)
                    begin
                        if (c == CH_BSLASH)
                            bs_next = 1'b1;
                        else
                        begin
                            req_v[r] = 1'b1;
                            req_code[r] = (c == CH_CR) ? CH_LF : c;
                            r = r + 2'd1;
                        end
                    end
                end
            end
            MODE_CMD:
            begin
                mode_next = MODE_TEXT;
                priority if (c == CMD_FONT)
                begin
                    mode_next = MODE_NAME;
                    plen_next = 6'd0;
                end
                else if (c == CMD_SIZE)
                begin
                    num_start = 1'b1;
                    tgt_next = TGT_SIZE;
                end
                else if (c == CMD_COLOR)
                begin
                    num_start = 1'b1;
                    tgt_next = TGT_COLOR;
                end
                else if (c == CMD_UNDER)
                begin
                    num_start = 1'b1;
                    tgt_next = TGT_UNDER;
                end
                else if (c == CMD_STYLE)
                begin
                    num_start = 1'b1;
                    tgt_next = TGT_STYLE;
                end
                else if (c == CMD_LINE)
                begin
                    req_v[r] = 1'b1;
                    req_code[r] = CH_LF;
                    r = r + 2'd1;
                    mode_next = MODE_SKIP;
                    plen_next = 6'd2;
                end
                else if (c == CH_BSLASH)
                begin
                    mode_next = MODE_SKIP;
                    plen_next = 6'd1;
                end
                else
                begin
                    mode_next = MODE_TEXT;
                end
                if (num_start)
                begin
                    mode_next  = MODE_NUM;
                    plen_next  = 6'd0;
                    acc_next   = 16'd0;
                    neg_next   = 1'b0;
                    digit_next = 1'b0;
                    ended_next = 1'b0;
                    sign_next  = 1'b0;
                end
            end
            MODE_NAME:
            begin
                if (c == CH_CARET)
                    mode_next = MODE_TEXT;
                else
                begin
                    plen_next = plen_next + 6'd1;
                    if (plen_next >= NAME_LIM)
                    begin
                        mode_next = MODE_SKIP;
                        plen_next = 6'd1;
                    end
                end
            end
            MODE_NUM:
            begin
                if (c == CH_CARET)
                begin
                    mode_next = MODE_TEXT;
                    if (digit_next)
                    begin
                        low = neg_next ? (8'd0 - acc_next[7:0]) : acc_next[7:0];
                        unique case (tgt_next)
                            TGT_COLOR: attr_next.color = low;
                            TGT_UNDER: attr_next.underline = low;
                            TGT_STYLE: attr_next.style = low;
                            TGT_SIZE:  attr_next.size = neg_next ? 16'd0 : acc_next;
                        endcase
                    end
                end
                else
                begin
                    if (!ended_next)
                    begin
                        priority if (!(sign_next || digit_next) &&
                                     (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                        begin
                            sign_next = sign_next;
                        end
                        else if (!(sign_next || digit_next) &&
                                 (c == CH_PLUS || c == CH_MINUS))
                        begin
                            sign_next = 1'b1;
                            neg_next = (c == CH_MINUS);
                        end
                        else if (c >= CH_ZERO && c <= CH_NINE)
                        begin
                            prod = ({4'd0, acc_next} << 3) + ({4'd0, acc_next} << 1) +
                                   {12'd0, c - CH_ZERO};
                            acc_next = (prod > 20'h0ffff) ? 16'hffff : prod[15:0];
                            digit_next = 1'b1;
                        end
                        else
                        begin
                            ended_next = 1'b1;
                        end
                    end
                    plen_next = plen_next + 6'd1;
                    if (plen_next >= NUM_LIM)
                    begin
                        mode_next = MODE_SKIP;
                        plen_next = 6'd1;
                    end
                end
            end
            default:
            begin
                if (plen_next != 6'd0)
                    plen_next = plen_next - 6'd1;
                if (plen_next == 6'd0)
                    mode_next = MODE_TEXT;
            end
        endcase

        if (fin_in)
        begin
            if (bs_next)
            begin
                req_v[r] = 1'b1;
                req_code[r] = CH_BSLASH;
                r = r + 2'd1;
            end
            req_v[r] = 1'b1;
            req_end[r] = 1'b1;
            mode_next  = MODE_TEXT;
            tgt_next   = TGT_COLOR;
            plen_next  = 6'd0;
            acc_next   = 16'd0;
            neg_next   = 1'b0;
            digit_next = 1'b0;
            ended_next = 1'b0;
            sign_next  = 1'b0;
            bs_next    = 1'b0;
            open_next  = 1'b0;
        end

        // full buffer: characters past the limit are dropped, end item always goes
        k = 2'd0;
        cc = cnt_next;
        for (int i = 0; i < MAX_PER_ITEM; i++)
        begin
            items[i] = '0;
            counts[i] = '0;
        end
        for (int i = 0; i < MAX_PER_ITEM; i++)
        begin
            if (req_v[i] && (req_end[i] || cc < CNT_MAX))
            begin
                if (!req_end[i])
                    cc = cc + CNT_W'(1);
                items[k].code = req_end[i] ? 8'd0 : req_code[i];
                items[k].attr = attr_next;
                items[k].eot = req_end[i];
                counts[k] = cc;
                k = k + 2'd1;
            end
        end
        cnt_next = cc;
        n_items = k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_TEXT;
            tgt_reg   <= TGT_COLOR;
            plen_reg  <= 6'd0;
            acc_reg   <= 16'd0;
            neg_reg   <= 1'b0;
            digit_reg <= 1'b0;
            ended_reg <= 1'b0;
            sign_reg  <= 1'b0;
            bs_reg    <= 1'b0;
            open_reg  <= 1'b0;
            attr_reg  <= '{color: RST_COLOR, underline: RST_UNDERLINE,
                           style: RST_STYLE, size: RST_SIZE};
            cnt_reg   <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            tgt_reg   <= tgt_next;
            plen_reg  <= plen_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            digit_reg <= digit_next;
            ended_reg <= ended_next;
            sign_reg  <= sign_next;
            bs_reg    <= bs_next;
            open_reg  <= open_next;
            attr_reg  <= attr_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: src/cmtp_outq.sv
// Result queue: takes up to three items per cycle, hands out one per cycle when pop_stall is low.
`timescale 1ns / 1ps

module cmtp_outq import cmtp_pkg::*; #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_n,
    input  logic [WIDTH-1:0] push_data [MAX_PER_ITEM],
    output logic             room,
    output logic             pop_valid,
    input  logic             pop_stall,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    logic [WIDTH-1:0] mem [OUTQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign pop       = pop_valid && !pop_stall;
    assign room      = (count_reg <= CNT_W'(OUTQ_DEPTH - MAX_PER_ITEM));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PER_ITEM; i++)
        begin
            if (2'(i) < push_n)
                mem[wr_ptr_reg + PTR_W'(i)] <= push_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/cmtp_checker.sv
// Port-level checks for the caret markup text parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmtp_checker #(
    parameter int MAX_CHARS = 2048,
    parameter int CNT_W     = $clog2(MAX_CHARS + 1)
) (
    input logic             clk,
    input logic             rst_n,
    input logic             text_valid,
    input logic             text_stall,
    input logic             char_valid,
    input logic             char_stall,
    input logic [7:0]       char_code,
    input logic [CNT_W-1:0] char_count,
    input logic             end_of_text
);

    // an empty input stage cannot start stalling on its own
    `CMTP_ASSERT(a_stall_needs_item, clk, rst_n, !text_valid && !text_stall |=> !text_stall, "stall raised with no item held")

    `CMTP_ASSERT(a_out_hold, clk, rst_n, char_valid && char_stall |=> char_valid, "output item dropped while stalled")

    `CMTP_ASSERT(a_end_code, clk, rst_n, char_valid && end_of_text |-> char_code == 8'd0, "end item with nonzero code")

    `CMTP_ASSERT(a_char_nonzero, clk, rst_n, char_valid && !end_of_text |-> char_code != 8'd0 && char_count != '0, "character item with zero code or count")

    `CMTP_ASSERT(a_count_bound, clk, rst_n, char_valid |-> char_count <= CNT_W'(MAX_CHARS), "count above limit")

endmodule

bind caret_markup_text_parser cmtp_checker #(
    .MAX_CHARS (MAX_CHARS),
    .CNT_W     (CNT_W)
) u_cmtp_checker (.*);
